>>> rtl/dcac_pkg.sv
// shared constants and types for the dilated convolution argmax counter
package dcac_pkg;

   // default sizes of the kernel group and sample line
   localparam int KERNELS_DEF     = 8;
   localparam int TAPS_DEF        = 9;
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int MAX_GAP_DEF     = 31;

   // field widths
   localparam int VALUE_W   = 16;
   localparam int WEIGHT_W  = 16;
   localparam int KIDX_W    = 3;
   localparam int TIDX_W    = 4;
   localparam int ACC_W     = 32;
   localparam int SOFT_W    = 16;
   localparam int HARD_W    = 10;
   localparam int COUNT_W   = 10;
   localparam int COUNT_MAX = 1023;

   // configuration registers
   localparam int GAP_CFG_W   = 5;
   localparam int WCNT_W      = 10;
   localparam int SHIFT_W     = 5;
   localparam int WCNT_RESET  = 140;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 10;

   // stream payload widths
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 32;

   typedef enum logic {
      ACT_WEIGHT = 1'b0,
      ACT_SAMPLE = 1'b1
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DILATION_GAP = 2'd0,
      CSR_WINDOW_COUNT = 2'd1,
      CSR_RESULT_SHIFT = 2'd2
   } csr_reg_type;

endpackage

>>> rtl/dcac_argpick.sv
// first strict maximum and first strict minimum over the kernel sums
module dcac_argpick import dcac_pkg::*; #(
   parameter int KERNELS = KERNELS_DEF
) (
   input  logic [ACC_W-1:0]             sums [KERNELS],
   output logic [$clog2(KERNELS)-1:0]   hi_idx,
   output logic [$clog2(KERNELS)-1:0]   lo_idx
);

   localparam int KI_W = $clog2(KERNELS);
   localparam int LVLS = KI_W;
   localparam int P    = 1 << LVLS;

   logic signed [ACC_W-1:0] hv [LVLS+1][P];
   logic signed [ACC_W-1:0] lv [LVLS+1][P];
   logic [KI_W-1:0]         hi_i [LVLS+1][P];
   logic [KI_W-1:0]         lo_i [LVLS+1][P];
   logic                    ok [LVLS+1][P];

   // pairwise tree, ties keep the lower kernel number
   always_comb begin
      for (int l = 0; l <= LVLS; l++) begin
         for (int i = 0; i < P; i++) begin
            hv[l][i]   = '0;
            lv[l][i]   = '0;
            hi_i[l][i] = '0;
            lo_i[l][i] = '0;
            ok[l][i]   = 1'b0;
         end
      end
      for (int i = 0; i < P; i++) begin
         ok[0][i]   = (i < KERNELS);
         hv[0][i]   = sums[i % KERNELS];
         lv[0][i]   = sums[i % KERNELS];
         hi_i[0][i] = KI_W'(i);
         lo_i[0][i] = KI_W'(i);
      end
      for (int l = 0; l < LVLS; l++) begin
         for (int i = 0; i < P / 2; i++) begin
            if (i < (P >> (l + 1))) begin
               ok[l+1][i] = ok[l][2*i];
               if (ok[l][2*i+1] && (hv[l][2*i+1] > hv[l][2*i])) begin
                  hv[l+1][i]   = hv[l][2*i+1];
                  hi_i[l+1][i] = hi_i[l][2*i+1];
               end else begin
                  hv[l+1][i]   = hv[l][2*i];
                  hi_i[l+1][i] = hi_i[l][2*i];
               end
               if (ok[l][2*i+1] && (lv[l][2*i+1] < lv[l][2*i])) begin
                  lv[l+1][i]   = lv[l][2*i+1];
                  lo_i[l+1][i] = lo_i[l][2*i+1];
               end else begin
                  lv[l+1][i]   = lv[l][2*i];
                  lo_i[l+1][i] = lo_i[l][2*i];
               end
            end
         end
      end
   end

   assign hi_idx = hi_i[LVLS][0];
   assign lo_idx = lo_i[LVLS][0];

endmodule

>>> rtl/dilated_conv_argmax_counter_top.sv
// top level of the dilated convolution argmax counter
//
// Usage: weight items (req_tuser low) load one signed weight of one kernel;
// sample items (req_tuser high) push one signal sample into the sample line.
// Each sample that completes a dilated window, up to window_count windows per
// pass, is convolved with every kernel; the strict maximum kernel adds its
// shifted sum into its soft total, the strict minimum kernel bumps its hard
// count. A sample with req_tlast high closes the pass: one result per kernel
// leaves on rsp_*, the last one with rsp_tlast, and the totals clear.
// Configuration goes through the csr_* write channel while the block is idle,
// a rule for the user that the block does not enforce. Throughput: one item
// per cycle while req_tready is high, through the stages input register, tap
// select and multiply, tap sum, argmax/argmin and accumulate. The result
// buffer sends one result per cycle while rsp_tready is high. A new pass end
// waits in the accumulate stage while the buffer still holds the previous
// pass, which stalls req_tready; otherwise a stalled receiver does not hold
// up the input. Reset clears counters, totals and the configuration
// registers (0, 140, 0); weights keep no reset value.
module dilated_conv_argmax_counter_top import dcac_pkg::*; #(
   parameter int KERNELS     = KERNELS_DEF,
   parameter int TAPS        = TAPS_DEF,
   parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
   parameter int MAX_GAP     = MAX_GAP_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // input channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // kernel_index, tap_index, value, zero pad
   input  logic                   req_tuser,   // action
   input  logic                   req_tlast,   // final_sample
   // result channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // kernel_id, soft_total, hard_total, zero pad
   output logic                   rsp_tlast,   // run_end
   // configuration write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int KI_W      = $clog2(KERNELS);
   localparam int GAP_W     = $clog2(MAX_GAP + 1);
   localparam int LINE_LEN  = (TAPS - 1) * (MAX_GAP + 1);
   localparam int PROD_W    = SAMPLE_BITS + WEIGHT_W;
   localparam int TIDX_LO   = KIDX_W;
   localparam int VALUE_LO  = KIDX_W + TIDX_W;
   localparam int RSP_PAD_W = RSP_TDATA_W - KIDX_W - SOFT_W - HARD_W;

   // configuration registers
   logic [GAP_CFG_W-1:0] dil_gap_ff, dil_gap_in;
   logic [WCNT_W-1:0]    win_count_ff, win_count_in;
   logic [SHIFT_W-1:0]   res_shift_ff, res_shift_in;

   // pipeline control
   logic adv;
   logic fire;

   // stage 0: input register
   logic                s0_valid_ff;
   action_type          s0_action_ff;
   logic [KIDX_W-1:0]   s0_kidx_ff;
   logic [TIDX_W-1:0]   s0_tidx_ff;
   logic [VALUE_W-1:0]  s0_value_ff;
   logic                s0_final_ff;

   // weights and sample line
   logic [WEIGHT_W-1:0]        weight_ff [KERNELS][TAPS];
   logic [SAMPLE_BITS-1:0]     line_ff [LINE_LEN];
   logic signed [SAMPLE_BITS-1:0] taps [TAPS];

   // pass counters
   logic [COUNT_W-1:0] seen_ff, seen_in, seen_inc;
   logic [COUNT_W-1:0] windows_ff, windows_in;
   logic [GAP_W-1:0]   gap_sat;
   logic [COUNT_W-1:0] span;
   logic               is_sample;
   logic               eval;

   // stage 1: products
   logic                     s1_valid_ff, s1_eval_ff, s1_final_ff;
   logic signed [PROD_W-1:0] prod_ff [KERNELS][TAPS];
   logic signed [PROD_W-1:0] prod_in [KERNELS][TAPS];

   // stage 2: kernel sums
   logic             s2_valid_ff, s2_eval_ff, s2_final_ff;
   logic [ACC_W-1:0] sum_ff [KERNELS];
   logic [ACC_W-1:0] sum_in [KERNELS];
   logic [KI_W-1:0]  pick_hi, pick_lo;

   // stage 3: winner and loser
   logic             s3_valid_ff, s3_eval_ff, s3_final_ff;
   logic [KI_W-1:0]  hi_ff, lo_ff;
   logic [ACC_W-1:0] win_ff;
   logic [ACC_W-1:0] win_shifted;

   // running totals
   logic [SOFT_W-1:0] soft_ff [KERNELS];
   logic [SOFT_W-1:0] soft_in [KERNELS];
   logic [HARD_W-1:0] hard_ff [KERNELS];
   logic [HARD_W-1:0] hard_in [KERNELS];

   // result buffer
   logic [SOFT_W-1:0] out_soft_ff [KERNELS];
   logic [HARD_W-1:0] out_hard_ff [KERNELS];
   logic [KI_W-1:0]   out_idx_ff, out_idx_in;
   logic              out_busy_ff, out_busy_in;
   logic              out_last;

   // configuration writes, always taken
   assign csr_ready = 1'b1;

   always_comb begin
      dil_gap_in   = dil_gap_ff;
      win_count_in = win_count_ff;
      res_shift_in = res_shift_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DILATION_GAP: dil_gap_in   = csr_data[GAP_CFG_W-1:0];
            CSR_WINDOW_COUNT: win_count_in = csr_data[WCNT_W-1:0];
            CSR_RESULT_SHIFT: res_shift_in = csr_data[SHIFT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dil_gap_ff   <= '0;
         win_count_ff <= WCNT_W'(WCNT_RESET);
         res_shift_ff <= '0;
      end else begin
         dil_gap_ff   <= dil_gap_in;
         win_count_ff <= win_count_in;
         res_shift_ff <= res_shift_in;
      end
   end

   // pipeline moves unless a pass end waits for the result buffer
   assign fire       = s3_valid_ff && !(s3_final_ff && out_busy_ff);
   assign adv        = fire || !s3_valid_ff;
   assign req_tready = adv;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
      end else if (adv) begin
         s0_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_action_ff <= action_type'(req_tuser);
         s0_kidx_ff   <= req_tdata[KIDX_W-1:0];
         s0_tidx_ff   <= req_tdata[TIDX_LO +: TIDX_W];
         s0_value_ff  <= req_tdata[VALUE_LO +: VALUE_W];
         s0_final_ff  <= req_tlast;
      end
   end

   // window geometry from the tap spacing
   always_comb begin
      if (int'(dil_gap_ff) > MAX_GAP) begin
         gap_sat = GAP_W'(MAX_GAP);
      end else begin
         gap_sat = GAP_W'(dil_gap_ff);
      end
      span = COUNT_W'((TAPS - 1) * (int'(gap_sat) + 1) + 1);
   end

   // sample counters and window decision
   assign is_sample = s0_valid_ff && (s0_action_ff == ACT_SAMPLE);
   assign seen_inc  = (seen_ff == COUNT_W'(COUNT_MAX)) ? seen_ff : seen_ff + COUNT_W'(1);
   assign eval      = (seen_inc >= span) && (windows_ff < win_count_ff);

   always_comb begin
      seen_in    = seen_ff;
      windows_in = windows_ff;
      if (adv && is_sample) begin
         if (s0_final_ff) begin
            seen_in    = '0;
            windows_in = '0;
         end else begin
            seen_in    = seen_inc;
            windows_in = windows_ff + COUNT_W'(eval);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff    <= '0;
         windows_ff <= '0;
      end else begin
         seen_ff    <= seen_in;
         windows_ff <= windows_in;
      end
   end

   // weight writes
   always_ff @(posedge clock) begin
      if (adv && s0_valid_ff && (s0_action_ff == ACT_WEIGHT)) begin
         for (int k = 0; k < KERNELS; k++) begin
            for (int t = 0; t < TAPS; t++) begin
               if ((int'(s0_kidx_ff) == k) && (int'(s0_tidx_ff) == t)) begin
                  weight_ff[k][t] <= s0_value_ff;
               end
            end
         end
      end
   end

   // sample line shift, newest at entry zero
   always_ff @(posedge clock) begin
      if (adv && is_sample) begin
         line_ff[0] <= s0_value_ff[SAMPLE_BITS-1:0];
         for (int i = 1; i < LINE_LEN; i++) begin
            line_ff[i] <= line_ff[i-1];
         end
      end
   end

   // tap select: last tap is the incoming sample, tap 0 the oldest
   always_comb begin
      for (int t = 0; t < TAPS; t++) begin
         taps[t] = '0;
      end
      for (int t = 0; t < TAPS - 1; t++) begin
         for (int g = 0; g <= MAX_GAP; g++) begin
            if (int'(gap_sat) == g) begin
               taps[t] = line_ff[(TAPS - 1 - t) * (g + 1) - 1];
            end
         end
      end
      taps[TAPS-1] = s0_value_ff[SAMPLE_BITS-1:0];
   end

   // one multiplier per weight
   always_comb begin
      for (int k = 0; k < KERNELS; k++) begin
         for (int t = 0; t < TAPS; t++) begin
            prod_in[k][t] = taps[t] * $signed(weight_ff[k][t]);
         end
      end
   end

   // stage 1 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= is_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_eval_ff  <= eval;
         s1_final_ff <= s0_final_ff;
         prod_ff     <= prod_in;
      end
   end

   // wrapping sum over the taps of each kernel
   always_comb begin
      for (int k = 0; k < KERNELS; k++) begin
         sum_in[k] = '0;
         for (int t = 0; t < TAPS; t++) begin
            sum_in[k] = sum_in[k] + ACC_W'(prod_ff[k][t]);
         end
      end
   end

   // stage 2 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_eval_ff  <= s1_eval_ff;
         s2_final_ff <= s1_final_ff;
         sum_ff      <= sum_in;
      end
   end

   // winner and loser selection
   dcac_argpick #(
      .KERNELS (KERNELS)
   ) u_argpick (
      .sums   (sum_ff),
      .hi_idx (pick_hi),
      .lo_idx (pick_lo)
   );

   // stage 3 registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_eval_ff  <= s2_eval_ff;
         s3_final_ff <= s2_final_ff;
         hi_ff       <= pick_hi;
         lo_ff       <= pick_lo;
         win_ff      <= sum_ff[pick_hi];
      end
   end

   // shifted winner and updated totals
   assign win_shifted = ACC_W'($signed(win_ff) >>> res_shift_ff);

   always_comb begin
      for (int k = 0; k < KERNELS; k++) begin
         soft_in[k] = soft_ff[k];
         hard_in[k] = hard_ff[k];
         if (s3_eval_ff && (int'(hi_ff) == k)) begin
            soft_in[k] = soft_ff[k] + win_shifted[SOFT_W-1:0];
         end
         if (s3_eval_ff && (int'(lo_ff) == k)) begin
            hard_in[k] = hard_ff[k] + HARD_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < KERNELS; k++) begin
            soft_ff[k] <= '0;
            hard_ff[k] <= '0;
         end
      end else if (fire) begin
         for (int k = 0; k < KERNELS; k++) begin
            if (s3_final_ff) begin
               soft_ff[k] <= '0;
               hard_ff[k] <= '0;
            end else begin
               soft_ff[k] <= soft_in[k];
               hard_ff[k] <= hard_in[k];
            end
         end
      end
   end

   // result buffer snapshot at the pass end
   always_ff @(posedge clock) begin
      if (fire && s3_final_ff) begin
         out_soft_ff <= soft_in;
         out_hard_ff <= hard_in;
      end
   end

   // result buffer sequencing, one transfer per kernel
   assign out_last = (out_idx_ff == KI_W'(KERNELS - 1));

   always_comb begin
      out_idx_in  = out_idx_ff;
      out_busy_in = out_busy_ff;
      if (fire && s3_final_ff) begin
         out_idx_in  = '0;
         out_busy_in = 1'b1;
      end else if (out_busy_ff && rsp_tready) begin
         if (out_last) begin
            out_busy_in = 1'b0;
         end else begin
            out_idx_in = out_idx_ff + KI_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_idx_ff  <= '0;
         out_busy_ff <= 1'b0;
      end else begin
         out_idx_ff  <= out_idx_in;
         out_busy_ff <= out_busy_in;
      end
   end

   // result channel
   assign rsp_tvalid = out_busy_ff;
   assign rsp_tlast  = out_last;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}},
                        out_hard_ff[out_idx_ff],
                        out_soft_ff[out_idx_ff],
                        KIDX_W'(out_idx_ff)};

endmodule
